>>> rtl/lgs_pkg.sv
package lgs_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int CSZ_W     = $clog2(MAX_COLS + 1);
   localparam int RSZ_W     = $clog2(MAX_ROWS + 1);
   localparam int ROW_W     = $clog2(MAX_ROWS + 2);
   localparam int CMP_W     = ROW_W + 1;

   localparam int RESET_ROWS = 1000;
   localparam int RESET_COLS = 1000;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = CSR_IDX_W'(1);

   localparam logic ACT_CELL  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   localparam int CCNT_W = 2;
   localparam int NBR_W  = 4;
   localparam logic [NBR_W-1:0] LIVE_KEEP  = NBR_W'(2);
   localparam logic [NBR_W-1:0] LIVE_BIRTH = NBR_W'(3);

   localparam int Q_DEPTH = 3;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
   localparam int QSUM_W  = QCNT_W + 1;

   // bit 0 = two rows above, bit 1 = one row above, bit 2 = newest row
   typedef logic [2:0] triple_type;

   typedef struct packed {
      logic top;
      logic mid;
      logic bot;
   } col_en_type;

   typedef struct packed {
      logic row_first;
      logic row_last;
      logic col_first;
      logic col_last;
   } pos_flags_type;

   typedef struct packed {
      logic       en;
      logic [COL_W-1:0] addr;
      logic [1:0] data;
   } line_wr_type;

   typedef struct packed {
      logic next_alive;
      logic last_of_frame;
   } out_beat_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   function automatic logic [RSZ_W-1:0] eff_rows(input logic [CFG_W-1:0] v);
      logic [RSZ_W-1:0] r;
      if (v == '0) begin
         r = RSZ_W'(1);
      end else if (v > MAX_ROWS) begin
         r = RSZ_W'(MAX_ROWS);
      end else begin
         r = RSZ_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CSZ_W-1:0] eff_cols(input logic [CFG_W-1:0] v);
      logic [CSZ_W-1:0] r;
      if (v == '0) begin
         r = CSZ_W'(1);
      end else if (v > MAX_COLS) begin
         r = CSZ_W'(MAX_COLS);
      end else begin
         r = CSZ_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CCNT_W-1:0] col_count(input triple_type t, input col_en_type en);
      return CCNT_W'(t[0] & en.top) + CCNT_W'(t[1] & en.mid) + CCNT_W'(t[2] & en.bot);
   endfunction

endpackage

>>> rtl/lgs_line_store.sv
module lgs_line_store (
   input  logic                       clock,
   input  lgs_pkg::line_wr_type       wr,
   input  logic [lgs_pkg::COL_W-1:0]  rd_addr,
   output logic [1:0]                 rd_data
);
   import lgs_pkg::*;

   logic [1:0] line_ff [MAX_COLS];
   logic [1:0] rd_raw_ff;
   logic [1:0] byp_data_ff;
   logic       byp_sel_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_ff[wr.addr] <= wr.data;
      end
      rd_raw_ff <= line_ff[rd_addr];
   end

   // write landing on the address being read in the same cycle
   always_ff @(posedge clock) begin
      byp_sel_ff  <= wr.en && (wr.addr == rd_addr);
      byp_data_ff <= wr.data;
   end

   assign rd_data = byp_sel_ff ? byp_data_ff : rd_raw_ff;

endmodule

>>> rtl/lgs_column_cell.sv
module lgs_column_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  lgs_pkg::triple_type         din,
   input  lgs_pkg::col_en_type         en,
   output lgs_pkg::triple_type         q,
   output logic [lgs_pkg::CCNT_W-1:0]  cnt
);
   import lgs_pkg::*;

   triple_type q_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= din;
      end
   end

   assign q   = q_ff;
   assign cnt = col_count(q_ff, en);

endmodule

>>> rtl/lgs_out_queue.sv
module lgs_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lgs_pkg::out_beat_type push_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lgs_pkg::out_beat_type rsp_beat,
   output lgs_pkg::q_stat_type   stat
);
   import lgs_pkg::*;

   out_beat_type      ent_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff;
   logic [QCNT_W-1:0] cnt_in;
   logic              pop;

   function automatic logic [QPTR_W-1:0] ptr_step(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign rsp_valid  = (cnt_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign rsp_beat   = ent_ff[rd_ptr_ff];
   assign stat.count = cnt_ff;

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

>>> rtl/life_generation_stencil.sv
// One generation of the B3/S23 life rule over a grid_rows x grid_cols grid (1..1024 each,
// 0 reads as 1 and larger values as 1024) sent in raster order, one cell per req beat;
// cells outside the grid are dead and nothing wraps. The result for a cell leaves one row
// plus one cell after the cell goes in, so after the last cell send grid_cols + 1 flush
// beats to drain the frame; a flush beat with no frame under way is taken and dropped, and
// rsp_last_of_frame marks the bottom-right cell. One beat is taken every clock while the
// output queue has room: the column line store is read as a beat is taken and written back
// the next cycle, the 3x3 window is a chain of column cells, and each rsp beat passes the
// s1 register and the output queue. A three-entry output queue absorbs rsp stalls. Writing
// grid_rows or grid_cols restarts the frame; write them only while the block is idle.
module life_generation_stencil (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic                            req_cell_alive,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_next_alive,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_wr_en,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]       csr_wdata
);
   import lgs_pkg::*;

   typedef struct packed {
      logic             emit;
      logic             alive;
      logic [COL_W-1:0] addr;
      pos_flags_type    flags;
      logic             last;
   } s1_type;

   logic [RSZ_W-1:0] rows_ff;
   logic [CSZ_W-1:0] cols_ff;
   logic [COL_W-1:0] ic_ff;
   logic [COL_W-1:0] ic_in;
   logic [ROW_W-1:0] ir_ff;
   logic [ROW_W-1:0] ir_in;
   logic             s1_vld_ff;
   logic             s1_vld_in;
   s1_type           s1_ff;
   s1_type           s1_in;

   logic             accept;
   logic             take;
   logic             csr_hit;
   logic             ic_nz;
   logic [CSZ_W-1:0] ic_inc;
   logic [CMP_W-1:0] ir_x;
   logic [CMP_W-1:0] rows_x;

   logic [1:0]        old_lines;
   triple_type        triple;
   line_wr_type       line_wr;
   triple_type        cell_a_q;
   triple_type        cell_b_q;
   col_en_type        en_new;
   col_en_type        en_a;
   col_en_type        en_b;
   logic [CCNT_W-1:0] cnt_new;
   logic [CCNT_W-1:0] cnt_a;
   logic [CCNT_W-1:0] cnt_b;
   logic [NBR_W-1:0]  nbr_cnt;
   logic              center;
   logic              push;
   out_beat_type      push_beat;
   out_beat_type      rsp_beat;
   q_stat_type        q_stat;

   // input side: position tracking and mask flags for the result this beat releases
   always_comb begin
      accept  = req_valid && req_ready;
      take    = accept && !((req_action == ACT_FLUSH) && (ir_ff == '0) && (ic_ff == '0));
      ic_nz   = (ic_ff != '0);
      ic_inc  = CSZ_W'(ic_ff) + CSZ_W'(1);
      ir_x    = CMP_W'(ir_ff);
      rows_x  = CMP_W'(rows_ff);

      s1_in.addr  = ic_ff;
      s1_in.alive = (req_action == ACT_CELL) && (ir_x < rows_x) && req_cell_alive;
      s1_in.emit  = (ir_x >= CMP_W'(2)) || ((ir_x == CMP_W'(1)) && ic_nz);
      if (ic_nz) begin
         s1_in.flags.row_first = (ir_x == CMP_W'(1));
         s1_in.flags.row_last  = (ir_x >= rows_x);
         s1_in.flags.col_first = (ic_ff == COL_W'(1));
         s1_in.flags.col_last  = 1'b0;
      end else begin
         s1_in.flags.row_first = (ir_x == CMP_W'(2));
         s1_in.flags.row_last  = (ir_x >= rows_x + CMP_W'(1));
         s1_in.flags.col_first = (cols_ff == CSZ_W'(1));
         s1_in.flags.col_last  = 1'b1;
      end
      s1_in.last = s1_in.emit && s1_in.flags.row_last && s1_in.flags.col_last;
      s1_vld_in  = take;

      ic_in = ic_ff;
      ir_in = ir_ff;
      if (take) begin
         if (s1_in.last) begin
            ic_in = '0;
            ir_in = '0;
         end else if (ic_inc == cols_ff) begin
            ic_in = '0;
            ir_in = ir_ff + ROW_W'(1);
         end else begin
            ic_in = ic_ff + COL_W'(1);
         end
      end
   end

   assign csr_hit = csr_wr_en && ((csr_index == CSR_GRID_ROWS) || (csr_index == CSR_GRID_COLS));

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= eff_rows(CFG_W'(RESET_ROWS));
         cols_ff   <= eff_cols(CFG_W'(RESET_COLS));
         ic_ff     <= '0;
         ir_ff     <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         if (csr_hit) begin
            ic_ff <= '0;
            ir_ff <= '0;
         end else begin
            ic_ff <= ic_in;
            ir_ff <= ir_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GRID_ROWS: begin
                  rows_ff <= eff_rows(csr_wdata);
               end
               CSR_GRID_COLS: begin
                  cols_ff <= eff_cols(csr_wdata);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   lgs_line_store u_line_store (
      .clock   (clock),
      .wr      (line_wr),
      .rd_addr (ic_ff),
      .rd_data (old_lines)
   );

   // old_lines bit 0 = one row above, bit 1 = two rows above
   assign triple       = {s1_ff.alive, old_lines[0], old_lines[1]};
   assign line_wr.en   = s1_vld_ff;
   assign line_wr.addr = s1_ff.addr;
   assign line_wr.data = {old_lines[0], s1_ff.alive};

   always_comb begin
      en_new.top = !s1_ff.flags.row_first && !s1_ff.flags.col_last;
      en_new.mid = !s1_ff.flags.col_last;
      en_new.bot = !s1_ff.flags.row_last && !s1_ff.flags.col_last;
      en_a.top   = !s1_ff.flags.row_first;
      en_a.mid   = 1'b0;
      en_a.bot   = !s1_ff.flags.row_last;
      en_b.top   = !s1_ff.flags.row_first && !s1_ff.flags.col_first;
      en_b.mid   = !s1_ff.flags.col_first;
      en_b.bot   = !s1_ff.flags.row_last && !s1_ff.flags.col_first;
   end

   // center column
   lgs_column_cell u_cell_a (
      .clock (clock),
      .shift (s1_vld_ff),
      .din   (triple),
      .en    (en_a),
      .q     (cell_a_q),
      .cnt   (cnt_a)
   );

   // left column
   lgs_column_cell u_cell_b (
      .clock (clock),
      .shift (s1_vld_ff),
      .din   (cell_a_q),
      .en    (en_b),
      .q     (cell_b_q),
      .cnt   (cnt_b)
   );

   always_comb begin
      cnt_new = col_count(triple, en_new);
      nbr_cnt = NBR_W'(cnt_new) + NBR_W'(cnt_a) + NBR_W'(cnt_b);
      center  = cell_a_q[1];
      push    = s1_vld_ff && s1_ff.emit;
      push_beat.next_alive    = center ? ((nbr_cnt == LIVE_KEEP) || (nbr_cnt == LIVE_BIRTH))
                                       : (nbr_cnt == LIVE_BIRTH);
      push_beat.last_of_frame = s1_ff.last;
   end

   lgs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat),
      .stat      (q_stat)
   );

   assign req_ready = (QSUM_W'(q_stat.count) + QSUM_W'(s1_vld_ff)) <= QSUM_W'(Q_DEPTH - 1);
   assign rsp_next_alive    = rsp_beat.next_alive;
   assign rsp_last_of_frame = rsp_beat.last_of_frame;

   // left column history ends the shift chain; only its neighbour count is used
   logic unused_left;
   assign unused_left = ^cell_b_q;

endmodule

>>> rtl/lgs_checker.sv
module lgs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_next_alive,
   input logic rsp_last_of_frame
);

   // stalled rsp beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_alive)
                                  && $stable(rsp_last_of_frame))
      else $error("rsp beat changed while stalled");

   // nothing pending right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // an empty output side only fills from a req beat that went through the s1 register
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp beat without a req beat two cycles before");

   // back pressure on req only when results are waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no rsp pending");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);
